/* hw/rtl/length_prefixed_deframer_assert.svh */
// Assertion macros for the length-prefixed deframer.
// Included by the top level; expects clk and rst_n in the including scope.
`ifndef LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_DEFRAMER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/lpd_pkg.sv */
// Shared constants and types for the length-prefixed deframer.
// Used by lpd_parse, lpd_out_reg and length_prefixed_deframer; no dependencies.
`default_nettype none

package lpd_pkg;

    // Default header word sizes, in bytes.
    localparam int TAG_BYTES_DEF    = 4;
    localparam int LENGTH_BYTES_DEF = 4;

    localparam int BYTE_W = 8;
    localparam int WORD_W = 32;

    // One result transfer.
    typedef struct packed {
        logic [WORD_W-1:0] tag;
        logic [BYTE_W-1:0] body;
        logic              last;
        logic              empty;
    } result_t;

endpackage

`default_nettype wire

/* hw/rtl/length_prefixed_deframer.sv */
// Top level of the length-prefixed deframer: header decode plus output register.
// Depends on lpd_pkg, lpd_parse, lpd_out_reg and length_prefixed_deframer_assert.svh.
`default_nettype none

// Takes one stream byte per cycle while in_stall is low and splits the
// stream into messages, each a little-endian tag word of TAG_BYTES bytes and
// a length word of LENGTH_BYTES bytes followed by the body. Every body byte
// leaves as one transfer carrying the tag (only its low four bytes), the final
// one marked last; a zero length gives a single transfer marked empty and last
// on the final header byte. Header bytes give no transfer. Throughput is one
// byte per cycle unless in_stall is high, and each result is registered in
// the two-entry output register, which lets the input keep flowing while one
// result waits; in_stall rises only when both entries are full.
module length_prefixed_deframer #(
    parameter int TAG_BYTES    = lpd_pkg::TAG_BYTES_DEF,
    parameter int LENGTH_BYTES = lpd_pkg::LENGTH_BYTES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [lpd_pkg::BYTE_W-1:0]    data_byte,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [lpd_pkg::WORD_W-1:0]         message_tag,
    output logic [lpd_pkg::BYTE_W-1:0]         body_byte,
    output logic                               last_byte,
    output logic                               empty_message
);

`include "length_prefixed_deframer_assert.svh"

    logic             in_xfer;
    logic             parse_valid;
    logic             parse_in_body;
    lpd_pkg::result_t parse_result;
    lpd_pkg::result_t out_data;

    assign in_xfer = in_valid && !in_stall;

    // Framing state and decode.
    lpd_parse #(
        .TAG_BYTES    (TAG_BYTES),
        .LENGTH_BYTES (LENGTH_BYTES)
    ) u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_xfer),
        .data_byte    (data_byte),
        .result       (parse_result),
        .result_valid (parse_valid),
        .in_body      (parse_in_body)
    );

    // Result register with skid entry.
    lpd_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (parse_valid),
        .push_data (parse_result),
        .full      (in_stall),
        .valid     (out_valid),
        .stall     (out_stall),
        .data      (out_data)
    );

    assign message_tag   = out_data.tag;
    assign body_byte     = out_data.body;
    assign last_byte     = out_data.last;
    assign empty_message = out_data.empty;

    // An empty message is a single closing transfer with a zero body byte.
    `LPD_ASSERT_SAME(a_empty_is_last, out_valid && empty_message, last_byte && (body_byte == 8'd0), "empty message transfer not last or body nonzero")
    // The skid entry only fills behind a waiting main entry.
    `LPD_ASSERT_SAME(a_stall_has_result, in_stall, out_valid, "input stalled with no result waiting")
    // After every body byte taken, a result is waiting on the next cycle.
    `LPD_ASSERT_NEXT(a_body_byte_out, in_xfer && parse_in_body, out_valid, "body byte produced no result")

endmodule

`default_nettype wire

/* hw/rtl/lpd_parse.sv */
// Framing state and per-byte decode for the length-prefixed deframer.
// Depends on lpd_pkg for the result type and field widths.
`default_nettype none

module lpd_parse #(
    parameter int TAG_BYTES    = lpd_pkg::TAG_BYTES_DEF,
    parameter int LENGTH_BYTES = lpd_pkg::LENGTH_BYTES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [lpd_pkg::BYTE_W-1:0]    data_byte,
    output lpd_pkg::result_t                   result,
    output logic                               result_valid,
    output logic                               in_body
);

    localparam int HEADER_BYTES = TAG_BYTES + LENGTH_BYTES;
    localparam int CNT_W        = $clog2(HEADER_BYTES);
    localparam int KEPT_TAG     = (TAG_BYTES < 4) ? TAG_BYTES : 4;

    logic                       in_body_reg, in_body_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [lpd_pkg::WORD_W-1:0] tag_reg, tag_next;
    logic [lpd_pkg::WORD_W-1:0] len_reg, len_next;
    logic [lpd_pkg::WORD_W-1:0] rem_reg, rem_next;
    logic [lpd_pkg::WORD_W-1:0] tag_new;
    logic [lpd_pkg::WORD_W-1:0] len_new;
    logic                       body_last;

    assign in_body = in_body_reg;

    // Header bytes land in their little-endian lane of the tag or length word.
    always_comb
    begin
        tag_new = tag_reg;
        len_new = len_reg;
        for (int i = 0; i < KEPT_TAG; i++)
        begin
            if (count_reg == CNT_W'(i))
            begin
                tag_new[8*i +: 8] = data_byte;
            end
        end
        for (int i = 0; i < LENGTH_BYTES; i++)
        begin
            if (count_reg == CNT_W'(TAG_BYTES + i))
            begin
                len_new[8*i +: 8] = data_byte;
            end
        end
    end

    assign body_last = (rem_reg <= lpd_pkg::WORD_W'(1));

    // Next framing state and the result caused by the accepted byte.
    always_comb
    begin
        in_body_next = in_body_reg;
        count_next   = count_reg;
        tag_next     = tag_reg;
        len_next     = len_reg;
        rem_next     = rem_reg;
        result       = '0;
        result_valid = 1'b0;
        if (accept)
        begin
            if (in_body_reg)
            begin
                result_valid = 1'b1;
                result.tag   = tag_reg;
                result.body  = data_byte;
                result.last  = body_last;
                if (body_last)
                begin
                    in_body_next = 1'b0;
                    count_next   = '0;
                    tag_next     = '0;
                    len_next     = '0;
                    rem_next     = '0;
                end
                else
                begin
                    rem_next = rem_reg - lpd_pkg::WORD_W'(1);
                end
            end
            else if (count_reg == CNT_W'(HEADER_BYTES - 1))
            begin
                count_next = '0;
                if (len_new == '0)
                begin
                    // A zero-length body ends the message on its final header byte.
                    result_valid = 1'b1;
                    result.tag   = tag_new;
                    result.last  = 1'b1;
                    result.empty = 1'b1;
                    tag_next     = '0;
                    len_next     = '0;
                    rem_next     = '0;
                end
                else
                begin
                    in_body_next = 1'b1;
                    tag_next     = tag_new;
                    len_next     = '0;
                    rem_next     = len_new;
                end
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
                tag_next   = tag_new;
                len_next   = len_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_body_reg <= 1'b0;
            count_reg   <= '0;
            tag_reg     <= '0;
            len_reg     <= '0;
            rem_reg     <= '0;
        end
        else
        begin
            in_body_reg <= in_body_next;
            count_reg   <= count_next;
            tag_reg     <= tag_next;
            len_reg     <= len_next;
            rem_reg     <= rem_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/lpd_out_reg.sv */
// Two-entry output register (main plus skid) for deframer results.
// Depends on lpd_pkg for the result type.
`default_nettype none

module lpd_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire lpd_pkg::result_t  push_data,
    output logic                   full,
    output logic                   valid,
    input  wire logic              stall,
    output lpd_pkg::result_t       data
);

    logic             main_valid_reg, main_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    lpd_pkg::result_t main_reg, main_next;
    lpd_pkg::result_t skid_reg, skid_next;
    logic             main_free;

    assign valid     = main_valid_reg;
    assign data      = main_reg;
    assign full      = skid_valid_reg;
    assign main_free = !main_valid_reg || !stall;

    // Refill the main entry from the skid first, then from a new push.
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (main_free)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_next       = push_data;
                skid_valid_next = push;
            end
            else
            begin
                main_next       = push_data;
                main_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

/* bench/tb.sv */
// Self-checking testbench for length_prefixed_deframer: streams framed messages in,
// predicts every result transfer and checks each one as it leaves the block.
// Depends on lpd_pkg and the length_prefixed_deframer RTL.

module tb;

    localparam int TAG_N      = lpd_pkg::TAG_BYTES_DEF;
    localparam int LEN_N      = lpd_pkg::LENGTH_BYTES_DEF;
    localparam int MAX_WAIT   = 17;
    localparam int TAIL_TICKS = 16;
    localparam int MAX_ERRORS_SHOWN = 10;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [31:0] message_tag;
    logic [7:0] body_byte;
    logic       last_byte;
    logic       empty_message;

    // Predicted framing state.
    logic        in_body;
    logic [3:0]  header_pos;
    logic [31:0] tag_word;
    logic [31:0] len_word;
    logic [31:0] remaining;

    lpd_pkg::result_t pending_results[$];
    int      errors = 0;
    int      bytes_sent = 0;
    int      send_quiet = 0;
    int      recv_quiet = 0;

    length_prefixed_deframer #(
        .TAG_BYTES   (TAG_N),
        .LENGTH_BYTES(LEN_N)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .message_tag  (message_tag),
        .body_byte    (body_byte),
        .last_byte    (last_byte),
        .empty_message(empty_message)
    );

    always #5 clk = ~clk;

    // Wait length for one transfer; now and then a run of transfers with no wait at all.
    function automatic int next_wait(inout int quiet);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            quiet = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic clear_message();
        in_body    = 1'b0;
        header_pos = '0;
        tag_word   = '0;
        len_word   = '0;
        remaining  = '0;
    endtask

    task automatic push_result(input logic [31:0] tag, input logic [7:0] body,
                               input logic last, input logic empty);
        lpd_pkg::result_t r;
        r.tag   = tag;
        r.body  = body;
        r.last  = last;
        r.empty = empty;
        pending_results.push_back(r);
    endtask

    // Advance the predicted framing state by one stream byte.
    task automatic deframe_byte(input logic [7:0] value);
        int unsigned pos;
        int unsigned idx;
        if (in_body)
        begin
            push_result(tag_word, value, remaining <= 1, 1'b0);
            if (remaining <= 1)
                clear_message();
            else
                remaining = remaining - 1;
        end
        else
        begin
            pos = header_pos;
            if (pos < TAG_N)
            begin
                // Tag bytes past the fourth are dropped.
                if (pos < 4)
                    tag_word = tag_word | (32'(value) << (8 * pos));
            end
            else
            begin
                idx = pos - TAG_N;
                if (idx < 4)
                    len_word = len_word | (32'(value) << (8 * idx));
            end
            pos++;
            if (pos >= TAG_N + LEN_N)
            begin
                header_pos = '0;
                if (len_word == 0)
                begin
                    push_result(tag_word, 8'h00, 1'b1, 1'b1);
                    clear_message();
                end
                else
                begin
                    in_body   = 1'b1;
                    remaining = len_word;
                end
            end
            else
                header_pos = pos[3:0];
        end
    endtask

    // Offer one byte after a random gap and hold it until the transfer happens.
    task automatic send_byte(input logic [7:0] value);
        int gap;
        gap = next_wait(send_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= value;
        do
            @(posedge clk);
        while (in_stall);
        deframe_byte(value);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [31:0] tag, input logic [31:0] len);
        for (int i = 0; i < TAG_N; i++)
            send_byte(i < 4 ? tag[8*i +: 8] : 8'($urandom_range(0, 255)));
        for (int i = 0; i < LEN_N; i++)
            send_byte(i < 4 ? len[8*i +: 8] : 8'h00);
    endtask

    task automatic send_message(input logic [31:0] tag, input logic [31:0] len);
        send_header(tag, len);
        for (int unsigned i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // Hold the input idle until every predicted result has been checked.
    task automatic drain();
        if (pending_results.size() != 0)
        begin
            in_valid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
        end
    endtask

    task automatic test_empty_message();
        send_message(32'h0000_0000, 32'd0);
    endtask

    task automatic test_full_tag_extreme_bytes();
        send_header(32'hFFFF_FFFF, 32'd2);
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    task automatic test_single_byte_body();
        send_message(32'hA5C3_0F81, 32'd1);
    endtask

    // Mostly short messages, some empty and some long enough to carry into
    // the second length byte; the input goes idle until drained now and then.
    task automatic test_random_messages(input int target);
        int          pick;
        logic [31:0] len;
        while (bytes_sent < target)
        begin
            pick = $urandom_range(0, 39);
            if (pick < 5)
                len = 0;
            else if (pick == 39)
                len = $urandom_range(250, 300);
            else
                len = $urandom_range(1, 24);
            send_message($urandom, len);
            if ($urandom_range(0, 19) == 0)
                drain();
        end
    endtask

    // A length of all ones: the body never ends within the run, so no
    // transfer may be marked last.
    task automatic test_largest_length();
        send_header($urandom, 32'hFFFF_FFFF);
        repeat (40) send_byte(8'($urandom_range(0, 255)));
    endtask

    // Receiver: random stall before each result transfer.
    initial
    begin
        int gap;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            gap = next_wait(recv_quiet);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    // Compare each result transfer with the oldest prediction.
    always @(posedge clk)
    begin
        lpd_pkg::result_t got;
        lpd_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.tag   = message_tag;
            got.body  = body_byte;
            got.last  = last_byte;
            got.empty = empty_message;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= MAX_ERRORS_SHOWN)
                    $display("unexpected result: tag %h body %h last %b empty %b",
                             got.tag, got.body, got.last, got.empty);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.tag !== want.tag || got.body !== want.body ||
                    got.last !== want.last || got.empty !== want.empty)
                begin
                    errors++;
                    if (errors <= MAX_ERRORS_SHOWN)
                        $display("mismatch: want %h %h %b %b, got %h %h %b %b",
                                 want.tag, want.body, want.last, want.empty,
                                 got.tag, got.body, got.last, got.empty);
                end
            end
        end
    end

    initial
    begin
        clear_message();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_message();
        test_full_tag_extreme_bytes();
        test_single_byte_body();
        drain();
        test_random_messages(1100);
        drain();
        test_largest_length();
        drain();

        repeat (TAIL_TICKS) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            errors += pending_results.size();
            $display("%0d predicted results never arrived", pending_results.size());
        end
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/lpd_pkg.sv
hw/rtl/lpd_parse.sv
hw/rtl/lpd_out_reg.sv
hw/rtl/length_prefixed_deframer.sv
bench/tb.sv
